@@ hdl/iec_pkg.sv @@
package iec_pkg;

    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SEQ_W   = 8;
    localparam int CODE_W  = 8;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PART  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam logic [1:0] FT_HEARTBEAT = 2'd0;
    localparam logic [1:0] FT_ACK       = 2'd1;
    localparam logic [1:0] FT_RESULT    = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NORMAL    = 8'd0;
    localparam logic [CODE_W-1:0] CODE_VISION_ER = 8'd3;

    localparam logic [1:0] TX_NONE      = 2'd0;
    localparam logic [1:0] TX_TRIGGER   = 2'd1;
    localparam logic [1:0] TX_ACK       = 2'd2;
    localparam logic [1:0] TX_HEARTBEAT = 2'd3;

    localparam logic [2:0] V_NONE       = 3'd0;
    localparam logic [2:0] V_ACCEPT     = 3'd1;
    localparam logic [2:0] V_DEFECT     = 3'd2;
    localparam logic [2:0] V_FAILSAFE   = 3'd3;
    localparam logic [2:0] V_VISIONLOST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_TMO   = 3'd4;

    localparam logic [CFG_W-1:0] RST_RETRY     = 16'd195;
    localparam logic [CFG_W-1:0] RST_BUDGET    = 16'd400;
    localparam logic [CFG_W-1:0] RST_PULSE     = 16'd120;
    localparam logic [CFG_W-1:0] RST_HB_PERIOD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_VIS_TMO   = 16'd3000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        frame_type;
        logic [SEQ_W-1:0]  frame_sequence;
        logic [CODE_W-1:0] frame_code;
        logic [7:0]        frame_aux;
    } t_item;

    typedef struct packed {
        logic [1:0]        tx_kind;
        logic [SEQ_W-1:0]  tx_sequence;
        logic [CODE_W-1:0] tx_code;
        logic              belt_run;
        logic              cylinder_on;
        logic [2:0]        verdict;
        logic [7:0]        confidence;
        logic              vision_alive;
    } t_result;

endpackage

@@ hdl/inspection_exchange_controller.sv @@
// Channel   Dir  tdata                                    tuser
// s_axis    in   seq[7:0] code[15:8] aux[23:16]           kind[1:0] frame_type[3:2]
// m_axis    out  see port comment (30 bits, 32 wide)      tx_kind[1:0]
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, one register per write
//
// One beat per cycle sustained while m_axis_tready stays high; a beat is held in the input
// register, then the control update and result go out through a two-entry output skid.
// Synchronous active-low reset restores register defaults, idle mode, belt on.
// Output stalls fill the skid; s_axis_tready drops only when both skid slots
// and the input register are occupied.
module inspection_exchange_controller
    import iec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // frame_sequence[7:0], frame_code[15:8], frame_aux[23:16]
    input  logic [23:0]          s_axis_tdata,
    // kind[1:0], frame_type[3:2]
    input  logic [3:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tx_sequence[7:0], tx_code[15:8], belt_run[16], cylinder_on[17],
    // verdict[20:18], confidence[28:21], vision_alive[29], zero[31:30]
    output logic [31:0]          m_axis_tdata,
    // tx_kind[1:0]
    output logic [1:0]           m_axis_tuser
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    skid_ready;
    logic    fire;
    t_result core_res;
    t_result out_res;

    assign fire          = r_in_valid && skid_ready;
    assign s_axis_tready = !r_in_valid || skid_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
            r_in_item  <= '{kind:           s_axis_tuser[1:0],
                            frame_type:     s_axis_tuser[3:2],
                            frame_sequence: s_axis_tdata[7:0],
                            frame_code:     s_axis_tdata[15:8],
                            frame_aux:      s_axis_tdata[23:16]};
        end
    end

    iec_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_in_item),
        .o_result   (core_res)
    );

    iec_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire),
        .i_data  (core_res),
        .o_ready (skid_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tuser = out_res.tx_kind;
    assign m_axis_tdata = {2'b00,
                           out_res.vision_alive,
                           out_res.confidence,
                           out_res.verdict,
                           out_res.cylinder_on,
                           out_res.belt_run,
                           out_res.tx_code,
                           out_res.tx_sequence};

endmodule

@@ hdl/iec_core.sv @@
module iec_core
    import iec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_fire,
    input  t_item                i_item,
    output t_result              o_result
);

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_EXCHANGE = 2'd1,
        MODE_PULSE    = 2'd2
    } t_mode;

    logic [CFG_W-1:0] r_retry, r_budget, r_pulse, r_hb_period, r_vis_tmo;

    t_mode            r_mode, n_mode;
    logic [SEQ_W-1:0] r_part_seq, n_part_seq;
    logic [SEQ_W-1:0] r_hb_seq, n_hb_seq;
    logic [CFG_W-1:0] r_elapsed, n_elapsed;
    logic             r_retry_done, n_retry_done;
    logic [CFG_W-1:0] r_pulse_left, n_pulse_left;
    logic [CFG_W-1:0] r_since_hb, n_since_hb;
    logic [CFG_W-1:0] r_since_vis, n_since_vis;
    logic             r_pending, n_pending;
    logic             r_belt_on, n_belt_on;

    logic             do_start;
    t_result          res;

    function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v);
        return (v == {CFG_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    always_comb begin
        n_mode       = r_mode;
        n_part_seq   = r_part_seq;
        n_hb_seq     = r_hb_seq;
        n_elapsed    = r_elapsed;
        n_retry_done = r_retry_done;
        n_pulse_left = r_pulse_left;
        n_since_hb   = r_since_hb;
        n_since_vis  = r_since_vis;
        n_pending    = r_pending;
        n_belt_on    = r_belt_on;
        do_start     = 1'b0;
        res          = '0;

        case (i_item.kind)
            KIND_TICK: begin
                n_since_vis = sat_inc(r_since_vis);
                n_since_hb  = sat_inc(r_since_hb);
                case (r_mode)
                    MODE_EXCHANGE: begin
                        n_elapsed = sat_inc(r_elapsed);
                        if (n_elapsed >= r_budget) begin
                            res.verdict  = V_FAILSAFE;
                            n_mode       = MODE_PULSE;
                            n_pulse_left = r_pulse;
                        end else if (!r_retry_done && n_elapsed >= r_retry) begin
                            n_retry_done    = 1'b1;
                            res.tx_kind     = TX_TRIGGER;
                            res.tx_sequence = r_part_seq;
                        end
                    end
                    MODE_PULSE: begin
                        if (r_pulse_left != '0) begin
                            n_pulse_left = r_pulse_left - 1'b1;
                        end
                        if (n_pulse_left == '0) begin
                            n_mode    = MODE_IDLE;
                            n_belt_on = 1'b1;
                        end
                    end
                    default: begin
                        do_start = r_pending;
                    end
                endcase
            end
            KIND_PART: begin
                if (r_mode == MODE_IDLE) begin
                    do_start = 1'b1;
                end else begin
                    n_pending = 1'b1;
                end
            end
            KIND_FRAME: begin
                n_since_vis = '0;
                if (r_mode == MODE_EXCHANGE) begin
                    if (i_item.frame_type == FT_RESULT &&
                        i_item.frame_sequence == r_part_seq) begin
                        if (i_item.frame_code > CODE_VISION_ER) begin
                            res.verdict  = V_FAILSAFE;
                            n_mode       = MODE_PULSE;
                            n_pulse_left = r_pulse;
                        end else begin
                            res.tx_kind     = TX_ACK;
                            res.tx_sequence = r_part_seq;
                            res.tx_code     = i_item.frame_code;
                            res.confidence  = i_item.frame_aux;
                            if (i_item.frame_code == CODE_NORMAL) begin
                                res.verdict = V_ACCEPT;
                                n_mode      = MODE_IDLE;
                                n_belt_on   = 1'b1;
                            end else begin
                                res.verdict  = (i_item.frame_code == CODE_VISION_ER) ?
                                               V_FAILSAFE : V_DEFECT;
                                n_mode       = MODE_PULSE;
                                n_pulse_left = r_pulse;
                            end
                        end
                    end
                end else if (i_item.frame_type == FT_HEARTBEAT) begin
                    res.tx_kind     = TX_ACK;
                    res.tx_sequence = i_item.frame_sequence;
                end
            end
            default: begin
            end
        endcase

        if (do_start) begin
            n_pending  = 1'b0;
            n_belt_on  = 1'b0;
            n_part_seq = r_part_seq + 1'b1;
            if (n_since_vis >= r_vis_tmo) begin
                res.verdict  = V_VISIONLOST;
                n_mode       = MODE_PULSE;
                n_pulse_left = r_pulse;
            end else begin
                n_mode          = MODE_EXCHANGE;
                n_elapsed       = '0;
                n_retry_done    = 1'b0;
                res.tx_kind     = TX_TRIGGER;
                res.tx_sequence = n_part_seq;
            end
        end

        if (i_item.kind == KIND_TICK && res.tx_kind == TX_NONE &&
            n_mode != MODE_EXCHANGE && n_since_hb >= r_hb_period) begin
            n_since_hb      = '0;
            n_hb_seq        = r_hb_seq + 1'b1;
            res.tx_kind     = TX_HEARTBEAT;
            res.tx_sequence = n_hb_seq;
        end

        res.belt_run     = n_belt_on;
        res.cylinder_on  = (n_mode == MODE_PULSE);
        res.vision_alive = (n_since_vis < r_vis_tmo);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry      <= RST_RETRY;
            r_budget     <= RST_BUDGET;
            r_pulse      <= RST_PULSE;
            r_hb_period  <= RST_HB_PERIOD;
            r_vis_tmo    <= RST_VIS_TMO;
            r_mode       <= MODE_IDLE;
            r_part_seq   <= '0;
            r_hb_seq     <= '0;
            r_elapsed    <= '0;
            r_retry_done <= 1'b0;
            r_pulse_left <= '0;
            r_since_hb   <= '0;
            r_since_vis  <= '0;
            r_pending    <= 1'b0;
            r_belt_on    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RETRY:     r_retry     <= i_cfg_data;
                    CFG_BUDGET:    r_budget    <= i_cfg_data;
                    CFG_PULSE:     r_pulse     <= i_cfg_data;
                    CFG_HB_PERIOD: r_hb_period <= i_cfg_data;
                    CFG_VIS_TMO:   r_vis_tmo   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_mode       <= n_mode;
                r_part_seq   <= n_part_seq;
                r_hb_seq     <= n_hb_seq;
                r_elapsed    <= n_elapsed;
                r_retry_done <= n_retry_done;
                r_pulse_left <= n_pulse_left;
                r_since_hb   <= n_since_hb;
                r_since_vis  <= n_since_vis;
                r_pending    <= n_pending;
                r_belt_on    <= n_belt_on;
            end
        end
    end

`ifndef SYNTHESIS
    a_part_stops_belt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.kind == KIND_PART && r_mode == MODE_IDLE
        |=> !r_belt_on && r_mode != MODE_IDLE)
        else $error("part in idle did not stop the belt");

    a_trigger_in_exchange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.tx_kind == TX_TRIGGER |=> r_mode == MODE_EXCHANGE)
        else $error("trigger sent outside an exchange");

    a_belt_off_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_IDLE |-> !r_belt_on)
        else $error("belt running while busy");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_part_seq) && $stable(r_mode) && $stable(r_hb_seq))
        else $error("state moved without a beat");
`endif

endmodule

@@ hdl/iec_out_skid.sv @@
module iec_out_skid
    import iec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_valid, r_skid_valid;
    t_result r_data, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_valid) begin
            if (r_skid_valid) begin
                r_data       <= r_skid;
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_valid;
                r_data  <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

endmodule
